// ----- rtl/swld_pkg.sv -----
// Shared types and constants for the sync-word length deframer.
// Used by swld_cfg, swld_core, swld_out and the top level.
package swld_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumSync  = 4;
  localparam int unsigned CfgAddrW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [NumSync-1:0] sync_word_t;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] RegSync0 = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSync1 = 2'd1;
  localparam logic [CfgAddrW-1:0] RegSync2 = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSync3 = 2'd3;

  // Sync word after reset, entry 0 is the first byte on the wire
  localparam sync_word_t SyncReset = {8'h00, 8'hD0, 8'hBA, 8'hDA};

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_SYNC3 = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DONE    = 1'b1
  } out_kind_e;

  typedef struct packed {
    out_kind_e kind;
    byte_t     payload;
    byte_t     position;
    byte_t     length;
  } result_t;

endpackage

// ----- rtl/swld_cfg.sv -----
// Sync word register bank for the deframer.
// Depends on swld_pkg for the register indexes and reset word.
module swld_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swld_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [swld_pkg::ByteW-1:0]     cfg_wdata_i,
  output swld_pkg::sync_word_t           sync_o
);
  import swld_pkg::*;

  sync_word_t sync_q, sync_d;

  // Decode the write index onto the four sync registers
  always_comb begin
    sync_d = sync_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegSync0: sync_d[0] = cfg_wdata_i;
        RegSync1: sync_d[1] = cfg_wdata_i;
        RegSync2: sync_d[2] = cfg_wdata_i;
        RegSync3: sync_d[3] = cfg_wdata_i;
        default:  sync_d = sync_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else begin
      sync_q <= sync_d;
    end
  end

  assign sync_o = sync_q;

endmodule

// ----- rtl/swld_core.sv -----
// Input register and frame parser state machine of the deframer.
// Depends on swld_pkg for the phase codes and the result record.
module swld_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [swld_pkg::ByteW-1:0]  s_tdata_i,
  input  swld_pkg::sync_word_t        sync_i,
  input  logic                        out_free_i,
  output logic                        res_valid_o,
  output swld_pkg::result_t           res_o
);
  import swld_pkg::*;

  logic   in_valid_q, in_valid_d;
  byte_t  in_byte_q, in_byte_d;
  phase_e phase_q, phase_d;
  byte_t  len_q, len_d;
  byte_t  cnt_q, cnt_d;
  logic   advance;
  logic   accept;
  logic   more_data;

  // Move the held beat into the parser when the result stage can take it
  assign advance    = in_valid_q && out_free_i;
  assign s_tready_o = !in_valid_q || advance;
  assign accept     = s_tvalid_i && s_tready_o;
  assign more_data  = cnt_q < len_q;

  assign in_valid_d = accept || (in_valid_q && !advance);
  assign in_byte_d  = accept ? s_tdata_i : in_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  // Next phase, length and count
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    if (advance) begin
      unique case (phase_q)
        PH_SYNC1: phase_d = (in_byte_q == sync_i[1]) ? PH_SYNC2 : PH_SYNC0;
        PH_SYNC2: phase_d = (in_byte_q == sync_i[2]) ? PH_SYNC3 : PH_SYNC0;
        PH_SYNC3: phase_d = (in_byte_q == sync_i[3]) ? PH_LEN : PH_SYNC0;
        PH_LEN: begin
          len_d   = in_byte_q;
          cnt_d   = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (more_data) begin
            cnt_d = cnt_q + 8'd1;
          end else begin
            cnt_d   = '0;
            phase_d = PH_SYNC0;
          end
        end
        // First sync byte; unused codes hunt the same way
        default: phase_d = (in_byte_q == sync_i[0]) ? PH_SYNC1 : PH_SYNC0;
      endcase
    end
  end

  // Result for the beat being parsed
  always_comb begin
    res_valid_o = advance && (phase_q == PH_DATA);
    res_o.length = len_q;
    if (more_data) begin
      res_o.kind     = KIND_PAYLOAD;
      res_o.payload  = in_byte_q;
      res_o.position = cnt_q;
    end else begin
      res_o.kind     = KIND_DONE;
      res_o.payload  = '0;
      res_o.position = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload count never passes the declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q <= len_q))
    else $error("payload count beyond declared length");

  // A completed frame goes back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PH_DATA && cnt_q == len_q) |=> (phase_q == PH_SYNC0))
    else $error("frame end did not return to hunt");

  // The length beat opens the payload with a cleared count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PH_LEN) |=> (phase_q == PH_DATA && cnt_q == '0))
    else $error("length beat did not open payload");

  // No beat is parsed while a result is stuck in the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_free_i |-> !res_valid_o)
    else $error("result produced while output stage full");

endmodule

// ----- rtl/swld_out.sv -----
// Result register of the deframer, drives the master-side stream.
// Depends on swld_pkg for the result record.
module swld_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         res_valid_i,
  input  swld_pkg::result_t            res_i,
  output logic                         out_free_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [3*swld_pkg::ByteW-1:0] m_tdata_o,
  output logic                         m_tuser_o
);
  import swld_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // Free when empty or when the held beat leaves this cycle
  assign out_free_o = !valid_q || m_tready_i;
  assign valid_d    = res_valid_i || (valid_q && !m_tready_i);
  assign res_d      = res_valid_i ? res_i : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {res_q.length, res_q.position, res_q.payload};
  assign m_tuser_o  = res_q.kind;

endmodule

// ----- rtl/sync_word_length_deframer_unit.sv -----
// Sync-word length-prefixed deframer: hunts for a four-byte sync word, reads one length
// byte and then streams that many payload bytes, each tagged with its position, followed
// by one frame-complete beat that consumes the next input byte. A byte passes through the
// input register and then the result register, and the unit accepts one byte per cycle;
// throughput is set only by the output stall, which holds the single result register and,
// through it, the input register. Sync bytes must be written through the configuration
// port at indexes 0 to 3 only while the stream is idle; the unit does not enforce this.
// Depends on swld_pkg, swld_cfg, swld_core and swld_out.
module sync_word_length_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave side, tdata: rx_byte[7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swld_pkg::ByteW-1:0]    s_axis_tdata,
  // Master side, tdata: payload_byte[7:0], byte_position[15:8], frame_length[23:16]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*swld_pkg::ByteW-1:0]  m_axis_tdata,
  // tuser: out_kind[0]
  output logic                          m_axis_tuser,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [swld_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [swld_pkg::ByteW-1:0]    cfg_wdata_i
);
  import swld_pkg::*;

  sync_word_t sync;
  logic       out_free;
  logic       res_valid;
  result_t    res;

  swld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sync_o      (sync)
  );

  swld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .sync_i      (sync),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  swld_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for sync_word_length_deframer_unit: byte stream in, payload and
// frame-complete beats out, compared against an in-bench deframer model.
// Depends on swld_pkg and the RTL of the unit.
module tb_top;
  import swld_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned SegItems    = 60;

  localparam logic [CfgAddrW-1:0] SyncRegs [NumSync] = '{RegSync0, RegSync1, RegSync2, RegSync3};

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  // One directed stimulus row; the result fields count only when has_want is set
  typedef struct packed {
    byte_t rx;
    bit    has_want;
    bit    kind;
    byte_t payload;
    byte_t pos;
    byte_t len;
  } dir_row_t;

  localparam dir_row_t DirRows [26] = '{
    // frame of three payload bytes, two with extreme values, then the closing byte
    '{8'hDA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hBA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hD0, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h03, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hFF, 1'b1, 1'b0, 8'hFF, 8'd0, 8'd3},
    '{8'h00, 1'b1, 1'b0, 8'h00, 8'd1, 8'd3},
    '{8'hA5, 1'b1, 1'b0, 8'hA5, 8'd2, 8'd3},
    '{8'h5A, 1'b1, 1'b1, 8'h00, 8'd0, 8'd3},
    // first sync byte wrong: keep hunting, the rest of the word must not frame
    '{8'hBA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hD0, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h44, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    // mismatch on the second byte is not rechecked as a first sync byte
    '{8'hDA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hDA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hBA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hD0, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    // zero-length frame: the byte after the length closes it at once
    '{8'hDA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hBA, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'hD0, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'd0, 8'd0},
    '{8'h77, 1'b1, 1'b1, 8'h00, 8'd0, 8'd0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  byte_t                 s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [3*ByteW-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]   cfg_addr_i    = '0;
  byte_t                 cfg_wdata_i   = '0;

  // Deframer model state
  sync_word_t  sync_cfg   = SyncReset;
  phase_e      hunt_phase = PH_SYNC0;
  byte_t       frame_len  = '0;
  byte_t       rx_count   = '0;

  result_t     deframed_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned rx_sent      = 0;
  int unsigned cycle_cnt    = 0;

  // Pacing controls
  bit          bursty     = 1'b0;
  bit          offer_open = 1'b0;
  int unsigned burst_left = 0;
  sink_mode_e  sink_mode  = SINK_OPEN;
  int unsigned hold_req   = 0;
  int unsigned hold_done  = 0;
  int unsigned hold_left  = 0;
  int unsigned sink_tick  = 0;

  sync_word_length_deframer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the deframer model by one byte; return 1 when it yields a beat
  function automatic bit deframe_byte(input byte_t b, output result_t r);
    r = '0;
    case (hunt_phase)
      PH_SYNC1: hunt_phase = (b == sync_cfg[1]) ? PH_SYNC2 : PH_SYNC0;
      PH_SYNC2: hunt_phase = (b == sync_cfg[2]) ? PH_SYNC3 : PH_SYNC0;
      PH_SYNC3: hunt_phase = (b == sync_cfg[3]) ? PH_LEN : PH_SYNC0;
      PH_LEN: begin
        frame_len  = b;
        rx_count   = '0;
        hunt_phase = PH_DATA;
      end
      PH_DATA: begin
        if (rx_count < frame_len) begin
          r = '{kind: KIND_PAYLOAD, payload: b, position: rx_count, length: frame_len};
          rx_count = rx_count + 1'b1;
        end else begin
          r = '{kind: KIND_DONE, payload: '0, position: '0, length: frame_len};
          rx_count   = '0;
          hunt_phase = PH_SYNC0;
        end
        return 1'b1;
      end
      default: hunt_phase = (b == sync_cfg[0]) ? PH_SYNC1 : PH_SYNC0;
    endcase
    return 1'b0;
  endfunction

  // Offer one byte, hold it until accepted, then queue its expected beat
  task automatic send_rx(input byte_t b, input bit has_want, input result_t want);
    result_t r;
    bit      has_r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    offer_open = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rx_sent++;
    has_r = deframe_byte(b, r);
    if (has_want) deframed_q.push_back(want);
    else if (has_r) deframed_q.push_back(r);
    // insert a gap at the end of each burst
    if (bursty) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        offer_open = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_byte(input byte_t b);
    send_rx(b, 1'b0, '0);
  endtask

  // Drop the offer, wait for every expected beat, then let the pipeline settle
  task automatic drain();
    if (offer_open) begin
      s_axis_tvalid <= 1'b0;
      offer_open = 1'b0;
    end
    do @(posedge clk_i); while (deframed_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_sync_word(input sync_word_t w);
    drain();
    foreach (SyncRegs[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= SyncRegs[i];
      cfg_wdata_i <= w[i];
      @(posedge clk_i);
      sync_cfg[i] = w[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  // Feed filler bytes until the model is back to hunting the first sync byte
  task automatic resync();
    while (hunt_phase != PH_SYNC0) send_byte(byte_t'($urandom));
  endtask

  task automatic send_frame(input byte_t len);
    resync();
    for (int i = 0; i < NumSync; i++) send_byte(sync_cfg[i]);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(byte_t'($urandom));
    send_byte(byte_t'($urandom));
  endtask

  // Correct sync prefix, then a wrong byte at a random position
  task automatic send_broken_sync();
    int unsigned k;
    k = $urandom_range(0, NumSync - 1);
    resync();
    for (int i = 0; i < k; i++) send_byte(sync_cfg[i]);
    send_byte(sync_cfg[k] ^ byte_t'($urandom_range(1, 255)));
  endtask

  // Noise leans on sync bytes so that partial matches show up
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) != 0) send_byte(sync_cfg[$urandom_range(0, NumSync - 1)]);
      else send_byte(byte_t'($urandom));
    end
  endtask

  task automatic run_segment(input int unsigned items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = rx_sent + items;
    while (rx_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 99) < 85) send_frame(byte_t'($urandom_range(0, 10)));
        else send_frame(byte_t'($urandom_range(0, 60)));
      end else if (pick < 85) begin
        send_broken_sync();
      end else begin
        send_noise();
      end
    end
  endtask

  // Receiver: long hold-off on request, otherwise stall per the current mode
  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_done != hold_req) begin
      m_axis_tready <= 1'b0;
      hold_done     <= hold_done + 1;
      hold_left     <= HoldCycles;
    end else begin
      case (sink_mode)
        SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: m_axis_tready <= ((sink_tick % 11) < 6);
        SINK_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:      m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: out_kind_e'(m_axis_tuser), payload: m_axis_tdata[7:0],
              position: m_axis_tdata[15:8], length: m_axis_tdata[23:16]};
      if (deframed_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat: kind %0d byte %02h pos %0d len %0d", $time,
                 got.kind, got.payload, got.position, got.length);
      end else begin
        want = deframed_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          $display("%0t: beat mismatch: expected kind %0d byte %02h pos %0d len %0d",
                   $time, want.kind, want.payload, want.position, want.length);
          $display("%0t:                  actual kind %0d byte %02h pos %0d len %0d",
                   $time, got.kind, got.payload, got.position, got.length);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    result_t    row_want;
    sync_word_t rand_word;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows with the reset sync word
    bursty    = 1'b1;
    sink_mode = SINK_RANDOM;
    foreach (DirRows[i]) begin
      row_want = '{kind: out_kind_e'(DirRows[i].kind), payload: DirRows[i].payload,
                   position: DirRows[i].pos, length: DirRows[i].len};
      send_rx(DirRows[i].rx, DirRows[i].has_want, row_want);
    end

    // Reset sync word, back-to-back input, open sink
    drain();
    bursty    = 1'b0;
    sink_mode = SINK_OPEN;
    run_segment(SegItems);

    // All-zero sync word; the sink holds off long enough to fill the unit
    load_sync_word({8'h00, 8'h00, 8'h00, 8'h00});
    bursty    = 1'b1;
    sink_mode = SINK_RANDOM;
    hold_req++;
    run_segment(SegItems);

    // All-ones sync word with one frame of maximum length
    load_sync_word({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    sink_mode = SINK_PATTERN;
    send_frame(8'hFF);
    run_segment(20);

    // Random sync word, sparse sink
    rand_word = {byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), byte_t'($urandom)};
    load_sync_word(rand_word);
    bursty    = 1'b0;
    sink_mode = SINK_SPARSE;
    run_segment(SegItems);

    // Repeated sync bytes make partial matches overlap
    load_sync_word({8'h5A, 8'h5A, 8'h5A, 8'h5A});
    bursty    = 1'b1;
    sink_mode = SINK_RANDOM;
    run_segment(SegItems);

    // Back to the reset sync word
    load_sync_word(SyncReset);
    sink_mode = SINK_PATTERN;
    run_segment(SegItems);

    drain();
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
